// ===== rtl/r4fft_pkg.sv =====
package r4fft_pkg;

  localparam int TwiddleDepthDefault = 1024;
  localparam int MaxLengthDefault    = 1024;

  localparam int DataW  = 32;
  localparam int TwW    = 18;
  localparam int IndexW = 10;
  localparam int OpW    = 2;
  localparam int CfgIdxW = 1;

  typedef enum logic [OpW-1:0] {
    OP_WRITE_TW   = 2'd0,
    OP_WRITE_SMP  = 2'd1,
    OP_RUN        = 2'd2,
    OP_READ_SMP   = 2'd3
  } op_t;

  localparam logic [CfgIdxW-1:0] REG_DIRECTION = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LOG4_LEN  = 1'd1;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic signed [DataW-1:0] sat34(input logic signed [DataW+1:0] x);
    logic signed [DataW+1:0] hi;
    logic signed [DataW+1:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (x > hi) sat34 = DataW'(hi);
    else if (x < lo) sat34 = DataW'(lo);
    else sat34 = x[DataW-1:0];
  endfunction

  // saturated add/sub of two 32-bit values
  function automatic logic signed [DataW-1:0] add_s(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    add_s = sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [DataW-1:0] sub_s(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    sub_s = sat34(34'(a) - 34'(b));
  endfunction

  // control from sequencer to datapath
  typedef struct packed {
    logic [1:0] term;    // which partial product
    logic       conj;
  } mul_ctl_t;

endpackage

// ===== rtl/r4fft_if.sv =====
interface r4fft_in_if;
  import r4fft_pkg::*;
  logic valid;
  logic ready;
  logic [OpW-1:0] operation;
  logic [IndexW-1:0] index;
  logic signed [DataW-1:0] real_part;
  logic signed [DataW-1:0] imag_part;
  modport source (output valid, operation, index, real_part, imag_part, input ready);
  modport sink (input valid, operation, index, real_part, imag_part, output ready);
endinterface

interface r4fft_out_if;
  import r4fft_pkg::*;
  logic valid;
  logic ready;
  logic signed [DataW-1:0] read_real;
  logic signed [DataW-1:0] read_imag;
  logic is_done;
  modport source (output valid, read_real, read_imag, is_done, input ready);
  modport sink (input valid, read_real, read_imag, is_done, output ready);
endinterface

interface r4fft_cfg_if;
  import r4fft_pkg::*;
  logic valid;
  logic ready;
  logic [CfgIdxW-1:0] index;
  logic [2:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/r4fft_cmul.sv =====
// shared complex multiplier: one 32x19 product per cycle, four per complex product
module r4fft_cmul (
  input  logic                    clk,
  input  r4fft_pkg::mul_ctl_t     ctl,
  input  logic signed [31:0]      ar,
  input  logic signed [31:0]      ai,
  input  logic signed [17:0]      wr,
  input  logic signed [17:0]      wi,
  output logic signed [31:0]      pr,
  output logic signed [31:0]      pi
);
  logic signed [31:0] a_op;
  logic signed [18:0] w_op;
  logic signed [50:0] prod;
  logic signed [51:0] acc_re;
  logic signed [51:0] acc_im;
  logic signed [51:0] sh_re;
  logic signed [51:0] sh_im;

  // term 0: ar*wr, 1: ai*wi, 2: ar*wi, 3: ai*wr
  always_comb begin
    logic signed [18:0] wi_eff;
    wi_eff = ctl.conj ? -19'(wi) : 19'(wi);
    case (ctl.term)
      2'd0: begin a_op = ar; w_op = 19'(wr); end
      2'd1: begin a_op = ai; w_op = wi_eff; end
      2'd2: begin a_op = ar; w_op = wi_eff; end
      default: begin a_op = ai; w_op = 19'(wr); end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= a_op * w_op;
  end

  // accumulate registered products (term index registered alongside them)
  logic [1:0] term_d;
  always_ff @(posedge clk) begin
    term_d <= ctl.term;
    case (term_d)
      2'd0: acc_re <= 52'(prod);
      2'd1: acc_re <= acc_re - 52'(prod);
      2'd2: acc_im <= 52'(prod);
      default: acc_im <= acc_im + 52'(prod);
    endcase
  end

  assign sh_re = acc_re >>> 16;
  assign sh_im = acc_im >>> 16;
  always_comb begin
    if (sh_re > 52'sd2147483647) pr = 32'sh7fffffff;
    else if (sh_re < -52'sd2147483648) pr = 32'sh80000000;
    else pr = sh_re[31:0];
    if (sh_im > 52'sd2147483647) pi = 32'sh7fffffff;
    else if (sh_im < -52'sd2147483648) pi = 32'sh80000000;
    else pi = sh_im[31:0];
  end
endmodule

// ===== rtl/radix4_fft_in_place_unit.sv =====
// channel  | role  | payload
// in       | sink  | operation, index, real_part, imag_part
// out      | src   | read_real, read_imag, is_done
// cfg      | sink  | index (0 direction, 1 log4_length), data
// a load is written from idle and loads stream back to back; a read passes RDW and RD, then the output handshake
// a run takes (N/4)*log4(N) butterflies, each stepped through LOAD, TWID, MUL, BFLY and STORE,
// paced by the single-port sample memory and the one shared multiplier
// a run of length one or of an unsupported length completes at once
// rst is synchronous; memories are not cleared, config returns to forward, length 4^5
// a result waiting on out blocks further input
module radix4_fft_in_place_unit #(
  parameter int TWIDDLE_DEPTH = r4fft_pkg::TwiddleDepthDefault,
  parameter int MAX_LENGTH    = r4fft_pkg::MaxLengthDefault
) (
  input logic clk,
  input logic rst,
  r4fft_in_if.sink   in_ch,
  r4fft_out_if.source out_ch,
  r4fft_cfg_if.sink  cfg
);
  import r4fft_pkg::*;

  localparam int SAW = $clog2(MAX_LENGTH);
  localparam int TAW = $clog2(TWIDDLE_DEPTH);
  localparam int TDL = $clog2(TWIDDLE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDW   = 9'b000000010,
    S_RD    = 9'b000000100,
    S_OUT   = 9'b000001000,
    S_LOAD  = 9'b000010000,
    S_TWID  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_BFLY  = 9'b010000000,
    S_STORE = 9'b100000000
  } state_t;

  state_t state;
  logic direction;
  logic [2:0] log4_length;

  // memories
  logic signed [31:0] smp_re [MAX_LENGTH];
  logic signed [31:0] smp_im [MAX_LENGTH];
  logic signed [17:0] tw_re [TWIDDLE_DEPTH];
  logic signed [17:0] tw_im [TWIDDLE_DEPTH];

  logic smp_we;
  logic [SAW-1:0] smp_addr;
  logic signed [31:0] smp_wre, smp_wim, smp_rre, smp_rim;
  logic [TAW-1:0] tw_addr;
  logic signed [17:0] tw_rre, tw_rim;

  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_re[smp_addr] <= smp_wre;
      smp_im[smp_addr] <= smp_wim;
    end
    smp_rre <= smp_re[smp_addr];
    smp_rim <= smp_im[smp_addr];
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.operation == OP_WRITE_TW
        && 32'(in_ch.index) < 32'(TWIDDLE_DEPTH)) begin
      tw_re[in_ch.index[TAW-1:0]] <= in_ch.real_part[17:0];
      tw_im[in_ch.index[TAW-1:0]] <= in_ch.imag_part[17:0];
    end
    tw_rre <= tw_re[tw_addr];
    tw_rim <= tw_im[tw_addr];
  end

  // config
  assign cfg.ready = (state == S_IDLE);
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      log4_length <= 3'd5;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_DIRECTION: direction <= cfg.data[0];
        REG_LOG4_LEN:  log4_length <= cfg.data;
        default: ;
      endcase
    end
  end

  // run sequencing state
  logic [4:0]  nlog;           // log2 N
  logic [4:0]  qlog;           // log2 q for current pass
  logic [16:0] grp;            // butterfly counter within pass
  logic [16:0] nbf;            // N/4
  logic [1:0]  leg;            // which of four points
  logic [2:0]  sub;            // sub-step counter
  logic signed [31:0] dr [4];
  logic signed [31:0] di [4];
  logic signed [31:0] hold_re, hold_im;
  logic is_done_r;
  logic out_valid;
  logic [SAW-1:0] rd_addr;
  logic rd_oor;

  // butterfly address: base + k + leg*q, base = (grp>>qlog)<<(qlog+2), k = grp mod q
  logic [16:0] k_of, base_of, pt_addr;
  logic [31:0] tw_idx;
  always_comb begin
    k_of    = grp & ((17'd1 << qlog) - 17'd1);
    base_of = (grp >> qlog) << (qlog + 5'd2);
    pt_addr = base_of + k_of + (17'(leg) << qlog);
    // stride is TWIDDLE_DEPTH / (4q)
    tw_idx  = (32'(k_of) * 32'(leg)) << (5'(TDL) - qlog - 5'd2);
  end

  logic fwd;
  assign fwd = !direction;
  logic signed [31:0] pr, pi;
  mul_ctl_t mctl;

  r4fft_cmul u_cmul (
    .clk(clk), .ctl(mctl),
    .ar(dr[leg]), .ai(di[leg]),
    .wr(tw_rre), .wi(tw_rim),
    .pr(pr), .pi(pi)
  );

  // butterfly core on registered points
  logic signed [31:0] e0r, e0i, e1r, e1i, o0r, o0i, o1r, o1i;
  logic signed [31:0] yr [4];
  logic signed [31:0] yi [4];
  always_comb begin
    e0r = add_s(dr[0], dr[2]); e0i = add_s(di[0], di[2]);
    e1r = sub_s(dr[0], dr[2]); e1i = sub_s(di[0], di[2]);
    o0r = add_s(dr[1], dr[3]); o0i = add_s(di[1], di[3]);
    o1r = sub_s(dr[1], dr[3]); o1i = sub_s(di[1], di[3]);
    yr[0] = add_s(e0r, o0r); yi[0] = add_s(e0i, o0i);
    yr[2] = sub_s(e0r, o0r); yi[2] = sub_s(e0i, o0i);
    if (fwd) begin
      yr[1] = add_s(e1r, o1i); yi[1] = sub_s(e1i, o1r);
      yr[3] = sub_s(e1r, o1i); yi[3] = add_s(e1i, o1r);
    end else begin
      yr[1] = sub_s(e1r, o1i); yi[1] = add_s(e1i, o1r);
      yr[3] = add_s(e1r, o1i); yi[3] = sub_s(e1i, o1r);
    end
  end

  // memory port mux
  always_comb begin
    smp_we = 1'b0;
    smp_addr = pt_addr[SAW-1:0];
    smp_wre = dr[leg];
    smp_wim = di[leg];
    tw_addr = tw_idx[TAW-1:0];
    mctl.term = sub[1:0];
    mctl.conj = direction;
    case (state)
      S_IDLE: begin
        smp_addr = in_ch.index[SAW-1:0];
        smp_wre = in_ch.real_part;
        smp_wim = in_ch.imag_part;
        smp_we = in_ch.valid && in_ch.operation == OP_WRITE_SMP
                 && 32'(in_ch.index) < 32'(MAX_LENGTH);
      end
      S_RDW, S_RD: smp_addr = rd_addr;
      S_STORE: smp_we = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.read_real = hold_re;
  assign out_ch.read_imag = hold_im;
  assign out_ch.is_done = is_done_r;

  logic len_ok;
  always_comb begin
    logic [31:0] n;
    n = 32'd1 << (2 * log4_length);
    len_ok = n <= 32'(MAX_LENGTH) && n <= 32'(TWIDDLE_DEPTH)
             && log4_length != 3'd0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            rd_addr <= in_ch.index[SAW-1:0];
            rd_oor <= 32'(in_ch.index) >= 32'(MAX_LENGTH);
            case (op_t'(in_ch.operation))
              OP_READ_SMP: state <= S_RDW;
              OP_RUN: begin
                nlog <= 5'(2 * log4_length);
                nbf <= 17'(32'd1 << (2 * log4_length - 2));
                qlog <= direction ? 5'd0 : 5'(2 * log4_length - 2);
                grp <= '0;
                leg <= '0;
                sub <= '0;
                if (len_ok) state <= S_LOAD;
                else begin
                  hold_re <= '0; hold_im <= '0; is_done_r <= 1'b1;
                  out_valid <= 1'b1; state <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDW: state <= S_RD;
        S_RD: begin
          hold_re <= rd_oor ? 32'sd0 : smp_rre;
          hold_im <= rd_oor ? 32'sd0 : smp_rim;
          is_done_r <= 1'b0;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        // load four points: address, wait, capture
        S_LOAD: begin
          if (sub == 3'd2) begin
            dr[leg] <= smp_rre; di[leg] <= smp_rim;
            sub <= '0;
            if (leg == 2'd3) begin
              // inverse multiplies before butterfly, forward after
              leg <= fwd ? 2'd0 : 2'd1;
              state <= fwd ? S_BFLY : S_TWID;
            end else begin
              leg <= leg + 2'd1;
            end
          end else begin
            sub <= sub + 3'd1;
          end
        end
        S_TWID: begin
          if (sub == 3'd1) begin
            sub <= '0;
            state <= S_MUL;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        // 4 product terms, 2 pipeline, then capture
        S_MUL: begin
          if (sub == 3'd5) begin
            dr[leg] <= pr; di[leg] <= pi;
            sub <= '0;
            if (leg == 2'd3) begin
              leg <= 2'd0;
              state <= fwd ? S_STORE : S_BFLY;
            end else begin
              leg <= leg + 2'd1;
              state <= S_TWID;
            end
          end else begin
            sub <= sub + 3'd1;
          end
        end
        S_BFLY: begin
          for (int j = 0; j < 4; j++) begin
            dr[j] <= yr[j]; di[j] <= yi[j];
          end
          leg <= fwd ? 2'd1 : 2'd0;
          state <= fwd ? S_TWID : S_STORE;
        end
        S_STORE: begin
          if (leg == 2'd3) begin
            leg <= '0;
            if (grp == nbf - 17'd1) begin
              grp <= '0;
              if ((fwd && qlog == 5'd0) || (!fwd && qlog + 5'd2 == nlog)) begin
                hold_re <= '0; hold_im <= '0; is_done_r <= 1'b1;
                out_valid <= 1'b1; state <= S_OUT;
              end else begin
                qlog <= fwd ? qlog - 5'd2 : qlog + 5'd2;
                state <= S_LOAD;
              end
            end else begin
              grp <= grp + 17'd1;
              state <= S_LOAD;
            end
          end else begin
            leg <= leg + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/r4fft_checker.sv =====
module r4fft_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic [r4fft_pkg::OpW-1:0] in_op,
  input logic out_valid,
  input logic out_ready,
  input logic out_done,
  input logic signed [r4fft_pkg::DataW-1:0] out_re,
  input logic cfg_ready
);
  import r4fft_pkg::*;

  // no new input while a result is pending
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // a done result carries zero read_real
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> out_re == 0) else $error("done carries data");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_re))
    else $error("result dropped");

  // a sample write returns to ready next cycle
  a_wr: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == OP_WRITE_SMP) |=> in_ready)
    else $error("write stalled");

  // config and input ready agree
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == in_ready) else $error("config ready mismatch");
endmodule

bind radix4_fft_in_place_unit r4fft_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.operation),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_done(out_ch.is_done),
  .out_re(out_ch.read_real), .cfg_ready(cfg.ready)
);

// ===== tb/tb_top.sv =====
module tb_top;
  import r4fft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 1024;
  localparam int StallLimit = 400000;
  localparam logic [31:0] MaxWord = 32'h7fff_ffff;
  localparam logic [31:0] MinWord = 32'h8000_0000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic done;
  } fft_result_t;

  typedef struct packed {
    logic typed;
    fft_result_t val;
  } result_note_t;

  typedef struct packed {
    row_kind_t kind;
    op_t op;
    logic [9:0] idx;
    logic [31:0] re;
    logic [31:0] im;
    logic typed;
    fft_result_t val;
  } stim_row_t;

  logic clk;
  logic rst;

  r4fft_in_if in_ch();
  r4fft_out_if out_ch();
  r4fft_cfg_if cfg();

  radix4_fft_in_place_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  int smp_re [Depth];
  int smp_im [Depth];
  int tw_re [Depth];
  int tw_im [Depth];
  bit inverse_mode;
  logic [2:0] len_log4;

  // stimulus-side bookkeeping of written entries
  bit smp_written [Depth];
  bit tw_written [Depth];

  fft_result_t expected_results[$];
  result_note_t pending_notes[$];

  int mismatches;
  int failures;
  int items_sent;
  int reads_checked;
  int runs_checked;
  int idle_mode;
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic int sum_sat(int a, int b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  function automatic int diff_sat(int a, int b);
    return sat32(longint'(a) - longint'(b));
  endfunction

  // complex product with Q2.16 twiddle, floor shift, saturation
  function automatic void twiddle_mul(input int ar, input int ai, input int widx,
                                      input bit cj, output int rr, output int ri);
    longint wr;
    longint wi;
    wr = tw_re[widx];
    wi = cj ? -longint'(tw_im[widx]) : longint'(tw_im[widx]);
    rr = sat32((longint'(ar) * wr - longint'(ai) * wi) >>> 16);
    ri = sat32((longint'(ar) * wi + longint'(ai) * wr) >>> 16);
  endfunction

  // forward decimation in frequency, natural in, digit reversed out
  function automatic void fft_forward(int n);
    int step;
    int ostep;
    int q;
    int p;
    int d0r, d0i, d1r, d1i, d2r, d2i, d3r, d3i;
    int e0r, e0i, e1r, e1i, o0r, o0i, o1r, o1i;
    int t1r, t1i, t2r, t2i, t3r, t3i;
    step = n;
    ostep = Depth / n;
    while (step >= 4) begin
      q = step >> 2;
      for (int base = 0; base < n; base += step) begin
        for (int k = 0; k < q; k++) begin
          p = base + k;
          d0r = smp_re[p];       d0i = smp_im[p];
          d1r = smp_re[p + q];   d1i = smp_im[p + q];
          d2r = smp_re[p + 2*q]; d2i = smp_im[p + 2*q];
          d3r = smp_re[p + 3*q]; d3i = smp_im[p + 3*q];
          e0r = sum_sat(d0r, d2r);  e0i = sum_sat(d0i, d2i);
          e1r = diff_sat(d0r, d2r); e1i = diff_sat(d0i, d2i);
          o0r = sum_sat(d1r, d3r);  o0i = sum_sat(d1i, d3i);
          o1r = diff_sat(d1r, d3r); o1i = diff_sat(d1i, d3i);
          smp_re[p] = sum_sat(e0r, o0r);
          smp_im[p] = sum_sat(e0i, o0i);
          t1r = sum_sat(e1r, o1i);  t1i = diff_sat(e1i, o1r);
          t2r = diff_sat(e0r, o0r); t2i = diff_sat(e0i, o0i);
          t3r = diff_sat(e1r, o1i); t3i = sum_sat(e1i, o1r);
          twiddle_mul(t1r, t1i, k * ostep, 1'b0, smp_re[p + q], smp_im[p + q]);
          twiddle_mul(t2r, t2i, 2 * k * ostep, 1'b0, smp_re[p + 2*q], smp_im[p + 2*q]);
          twiddle_mul(t3r, t3i, 3 * k * ostep, 1'b0, smp_re[p + 3*q], smp_im[p + 3*q]);
        end
      end
      step >>= 2;
      ostep <<= 2;
    end
  endfunction

  // inverse decimation in time with conjugated twiddles, no scaling
  function automatic void fft_inverse(int n);
    int step;
    int ostep;
    int q;
    int p;
    int t0r, t0i, t1r, t1i, t2r, t2i, t3r, t3i;
    int e0r, e0i, e1r, e1i, o0r, o0i, o1r, o1i;
    step = 4;
    ostep = Depth / 4;
    while (step <= n) begin
      q = step >> 2;
      for (int base = 0; base < n; base += step) begin
        for (int k = 0; k < q; k++) begin
          p = base + k;
          t0r = smp_re[p];
          t0i = smp_im[p];
          twiddle_mul(smp_re[p + q], smp_im[p + q], k * ostep, 1'b1, t1r, t1i);
          twiddle_mul(smp_re[p + 2*q], smp_im[p + 2*q], 2 * k * ostep, 1'b1, t2r, t2i);
          twiddle_mul(smp_re[p + 3*q], smp_im[p + 3*q], 3 * k * ostep, 1'b1, t3r, t3i);
          e0r = sum_sat(t0r, t2r);  e0i = sum_sat(t0i, t2i);
          e1r = diff_sat(t0r, t2r); e1i = diff_sat(t0i, t2i);
          o0r = sum_sat(t1r, t3r);  o0i = sum_sat(t1i, t3i);
          o1r = diff_sat(t1r, t3r); o1i = diff_sat(t1i, t3i);
          smp_re[p] = sum_sat(e0r, o0r);
          smp_im[p] = sum_sat(e0i, o0i);
          smp_re[p + q] = diff_sat(e1r, o1i);
          smp_im[p + q] = sum_sat(e1i, o1r);
          smp_re[p + 2*q] = diff_sat(e0r, o0r);
          smp_im[p + 2*q] = diff_sat(e0i, o0i);
          smp_re[p + 3*q] = sum_sat(e1r, o1i);
          smp_im[p + 3*q] = diff_sat(e1i, o1r);
        end
      end
      step <<= 2;
      ostep >>= 2;
    end
  endfunction

  // apply one accepted transaction to the predictor state
  function automatic bit fft_predict(op_t op, logic [9:0] idx, logic [31:0] re,
                                     logic [31:0] im, output fft_result_t res);
    longint n;
    res = '0;
    case (op)
      OP_WRITE_TW: begin
        tw_re[idx] = int'($signed(re[17:0]));
        tw_im[idx] = int'($signed(im[17:0]));
        return 1'b0;
      end
      OP_WRITE_SMP: begin
        smp_re[idx] = re;
        smp_im[idx] = im;
        return 1'b0;
      end
      OP_RUN: begin
        n = longint'(1) << (2 * len_log4);
        if (n <= Depth && (Depth % n) == 0) begin
          if (inverse_mode) fft_inverse(int'(n));
          else fft_forward(int'(n));
        end
        res.done = 1'b1;
        return 1'b1;
      end
      default: begin
        res.re = smp_re[idx];
        res.im = smp_im[idx];
        return 1'b1;
      end
    endcase
  endfunction

  // input and config monitor feeding the predictor
  always @(posedge clk) begin
    result_note_t note;
    fft_result_t res;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_DIRECTION) inverse_mode <= cfg.data[0];
        else len_log4 <= cfg.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        note = pending_notes.pop_front();
        if (fft_predict(op_t'(in_ch.operation), in_ch.index, in_ch.real_part,
                        in_ch.imag_part, res))
          expected_results.push_back(note.typed ? note.val : res);
      end
    end
  end

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    failures++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h actual %0h", what, exp_v, got_v);
  endtask

  // result checker
  always @(posedge clk) begin
    fft_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        failures++;
        $display("unexpected result transaction re %0h im %0h done %0b",
                 out_ch.read_real, out_ch.read_imag, out_ch.is_done);
      end else begin
        want = expected_results.pop_front();
        if (want.re !== out_ch.read_real) report("read_real", want.re, out_ch.read_real);
        if (want.im !== out_ch.read_imag) report("read_imag", want.im, out_ch.read_imag);
        if (want.done !== out_ch.is_done) report("is_done", want.done, out_ch.is_done);
        if (want.done) runs_checked++;
        else reads_checked++;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("radix4_fft_in_place_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver side: random stalls and long hold-off
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ch.ready <= ($urandom_range(99) >= 65);
    end else if (idle_mode == 3) begin
      out_ch.ready <= ($urandom_range(99) >= 8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // send one transaction, returns at the falling edge after acceptance
  task automatic send_item(op_t op, logic [9:0] idx, logic [31:0] re, logic [31:0] im,
                           logic typed = 1'b0, fft_result_t val = '0);
    int gap;
    gap = (idle_mode == 1) ? 65 : (idle_mode == 3) ? 8 : 0;
    while ($urandom_range(99) < gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pending_notes.push_back('{typed, val});
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.index <= idx;
    in_ch.real_part <= re;
    in_ch.imag_part <= im;
    if (op == OP_WRITE_TW) tw_written[idx] = 1'b1;
    if (op == OP_WRITE_SMP) smp_written[idx] = 1'b1;
    items_sent++;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // stop offering and wait for every expected result plus load latency
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0 || pending_notes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] ridx, logic [2:0] data);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.index <= ridx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      2: case ($urandom_range(3))
           0: return MaxWord;
           1: return MinWord;
           2: return 32'd0;
           default: return 32'hffff_ffff;
         endcase
      default: return 32'($signed($urandom) >>> 12);
    endcase
  endfunction

  // twiddle: low 18 bits count, upper bits are junk
  function automatic logic [31:0] rand_twiddle();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(1)) w[17:0] = 18'($signed($urandom_range(131072)) - 65536);
    return w;
  endfunction

  // make sure every sample and twiddle a run of length n touches is written
  task automatic fill_for_run(int n);
    int step;
    int ostep;
    int w;
    for (int i = 0; i < n; i++)
      if (!smp_written[i]) send_item(OP_WRITE_SMP, 10'(i), rand_sample(), rand_sample());
    step = n;
    while (step >= 4) begin
      ostep = Depth / step;
      for (int k = 0; k < step / 4; k++)
        for (int m = 1; m <= 3; m++) begin
          w = m * k * ostep;
          if (!tw_written[w]) send_item(OP_WRITE_TW, 10'(w), rand_twiddle(), rand_twiddle());
        end
      step >>= 2;
    end
  endtask

  // one setting: random loads, reads and runs
  task automatic random_phase(bit dir, logic [2:0] l4, int mode, int count, int max_runs);
    int n;
    int r;
    int runs;
    int idx;
    write_reg(REG_DIRECTION, {2'($urandom), dir});
    write_reg(REG_LOG4_LEN, l4);
    idle_mode = mode;
    n = (l4 <= 5) ? (1 << (2 * l4)) : Depth;
    runs = 0;
    for (int i = 0; i < count; i++) begin
      // receiver holds off while reads keep coming
      if (i == count / 2) begin
        hold_requests++;
        for (int j = 0; j < 8; j++) send_item(OP_READ_SMP, 10'd0, $urandom, $urandom);
      end
      r = $urandom_range(99);
      if (r < 35) begin
        idx = ($urandom_range(9) == 0) ? $urandom_range(Depth - 1) : $urandom_range(n - 1);
        send_item(OP_WRITE_SMP, 10'(idx), rand_sample(), rand_sample());
      end else if (r < 50) begin
        send_item(OP_WRITE_TW, 10'($urandom), rand_twiddle(), rand_twiddle());
      end else if (r < 85 || runs >= max_runs) begin
        idx = $urandom_range(Depth - 1);
        for (int t = 0; t < 4 && !smp_written[idx]; t++) idx = $urandom_range(n - 1);
        if (!smp_written[idx]) idx = 0;
        send_item(OP_READ_SMP, 10'(idx), $urandom, $urandom);
      end else begin
        if (l4 <= 5) fill_for_run(n);
        send_item(OP_RUN, 10'($urandom), $urandom, $urandom);
        runs++;
      end
    end
  endtask

  // directed rows: extremes, each operation, length one, unsupported length
  stim_row_t directed_rows [0:24] = '{
    '{ROW_ITEM, OP_WRITE_SMP, 10'd0, MaxWord, MinWord, 1'b0, '0},
    '{ROW_ITEM, OP_READ_SMP, 10'd0, 32'd0, 32'd0, 1'b1, '{MaxWord, MinWord, 1'b0}},
    '{ROW_ITEM, OP_WRITE_SMP, 10'd1023, MinWord, MaxWord, 1'b0, '0},
    '{ROW_ITEM, OP_READ_SMP, 10'd1023, 32'd0, 32'd0, 1'b1, '{MinWord, MaxWord, 1'b0}},
    '{ROW_CFG, OP_WRITE_TW, 10'(REG_LOG4_LEN), 32'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_RUN, 10'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_ITEM, OP_READ_SMP, 10'd0, 32'd0, 32'd0, 1'b1, '{MaxWord, MinWord, 1'b0}},
    '{ROW_CFG, OP_WRITE_TW, 10'(REG_LOG4_LEN), 32'd1, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_WRITE_SMP, 10'd1, 32'd1000, -32'sd1000, 1'b0, '0},
    '{ROW_ITEM, OP_WRITE_SMP, 10'd2, MaxWord, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_WRITE_SMP, 10'd3, -32'sd5, 32'd7, 1'b0, '0},
    '{ROW_ITEM, OP_WRITE_TW, 10'd0, 32'hfff2_0000, 32'h0002_0000, 1'b0, '0},
    '{ROW_ITEM, OP_RUN, 10'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_ITEM, OP_READ_SMP, 10'd0, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_READ_SMP, 10'd1, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_READ_SMP, 10'd2, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_READ_SMP, 10'd3, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, OP_WRITE_TW, 10'(REG_DIRECTION), 32'd1, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_RUN, 10'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_ITEM, OP_READ_SMP, 10'd0, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_READ_SMP, 10'd2, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG, OP_WRITE_TW, 10'(REG_LOG4_LEN), 32'd7, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_RUN, 10'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ROW_ITEM, OP_READ_SMP, 10'd1, 32'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, OP_READ_SMP, 10'd1023, 32'd0, 32'd0, 1'b1, '{MinWord, MaxWord, 1'b0}}
  };

  // main sequence
  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.index = '0;
    in_ch.real_part = '0;
    in_ch.imag_part = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    inverse_mode = 1'b0;
    len_log4 = 3'd5;
    idle_mode = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    failures = 0;
    items_sent = 0;
    reads_checked = 0;
    runs_checked = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(CfgIdxW'(directed_rows[i].idx), directed_rows[i].re[2:0]);
      else
        send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].re,
                  directed_rows[i].im, directed_rows[i].typed, directed_rows[i].val);
    end

    random_phase(1'b0, 3'd1, 0, 50, 8);
    random_phase(1'b1, 3'd1, 1, 50, 8);
    random_phase(1'b0, 3'd2, 2, 50, 6);
    random_phase(1'b1, 3'd2, 3, 50, 6);
    random_phase(1'b0, 3'd3, 0, 50, 4);
    random_phase(1'b1, 3'd3, 1, 50, 4);
    random_phase(1'b0, 3'd0, 2, 40, 6);
    random_phase(1'b1, 3'd7, 3, 40, 4);
    random_phase(1'b0, 3'd6, 0, 30, 3);
    random_phase(1'b1, 3'd4, 2, 40, 2);
    random_phase(1'b0, 3'd5, 1, 30, 1);
    random_phase(1'b1, 3'd5, 0, 30, 1);

    wait_idle();
    repeat (40) @(negedge clk);
    $display("covered %0d transactions: %0d reads and %0d runs checked", items_sent,
             reads_checked, runs_checked);
    $display("lengths 1 to 1024 and unsupported, both directions, %0d mismatches", mismatches);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("radix4_fft_in_place_unit regression: pass");
    end else begin
      $display("radix4_fft_in_place_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/r4fft_pkg.sv
rtl/r4fft_if.sv
rtl/r4fft_cmul.sv
rtl/radix4_fft_in_place_unit.sv
rtl/r4fft_checker.sv
tb/tb_top.sv
